/* rtl/ybd_pkg.sv */
// Shared constants, types and anchor table for the YOLO box decoder.
package ybd_pkg;

    localparam int unsigned ANCHORS_PER_LAYER = 3;

    // configuration register indexes
    localparam logic [2:0] CFG_CONF_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_ZERO_POINT_A   = 3'd1;
    localparam logic [2:0] CFG_ZERO_POINT_B   = 3'd2;
    localparam logic [2:0] CFG_SCALE_A        = 3'd3;
    localparam logic [2:0] CFG_SCALE_B        = 3'd4;
    localparam logic [2:0] CFG_CELL_PIXELS_A  = 3'd5;
    localparam logic [2:0] CFG_CELL_PIXELS_B  = 3'd6;

    localparam logic [15:0] CONF_THRESHOLD_RST = 16'd45875;
    localparam logic [23:0] SCALE_RST          = 24'd65536;
    localparam logic [8:0]  CELL_PIXELS_A_RST  = 9'd32;
    localparam logic [8:0]  CELL_PIXELS_B_RST  = 9'd16;

    localparam int unsigned DIV_STEPS = 17;   // quotient bits of 2^32 / (65536 + e)
    localparam int unsigned EXP_LAT   = 6;

    localparam logic [11:0] COORD_MAX = 12'hFFF;

    typedef struct packed {
        logic       valid;
        logic [5:0] row;
        logic [5:0] col;
        logic       layer;
        logic [1:0] slot;
    } t_meta;

    typedef struct packed {
        logic [31:0] ew;
        logic [31:0] eh;
    } t_exp_pair;

    // anchor sizes in Q16 pixels
    function automatic logic [22:0] anchor_w(input logic layer, input logic [1:0] slot);
        logic [22:0] v;
        case ({layer, slot})
            3'b000:  v = 23'd5414912;
            3'b001:  v = 23'd1938773;
            3'b010:  v = 23'd699051;
            3'b100:  v = 23'd2599595;
            3'b101:  v = 23'd3730091;
            3'b110:  v = 23'd1409024;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    function automatic logic [22:0] anchor_h(input logic layer, input logic [1:0] slot);
        logic [22:0] v;
        case ({layer, slot})
            3'b000:  v = 23'd7247796;
            3'b001:  v = 23'd4805973;
            3'b010:  v = 23'd1194212;
            3'b100:  v = 23'd2796203;
            3'b101:  v = 23'd4252558;
            3'b110:  v = 23'd2126279;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/yolo_box_decode_core.sv */
// Top level of the YOLO anchor-slot box decoder.
//
// Decodes one anchor slot per beat: the five int8 raw values are dequantized
// with the selected layer's zero point and scale, y/x/confidence go through
// fixed-point sigmoid, w/h through exp scaled by the anchor size. A beat goes
// out only when the confidence sigmoid is strictly above the threshold.
// Throughput is one slot per clock unless the output stalls. A slot passes
// one dequant stage, six exp stages, seventeen stages of the bit-per-stage
// sigmoid divider, one scaling stage and one output stage.
// The whole pipeline advances together; it holds only while a finished
// beat sits in the output register under stall. Configuration writes are
// always ready and must be made while no slot is in flight.
module yolo_box_decode_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    // input slot
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [7:0]  i_raw_y,
    input  logic signed [7:0]  i_raw_x,
    input  logic signed [7:0]  i_raw_w,
    input  logic signed [7:0]  i_raw_h,
    input  logic signed [7:0]  i_raw_conf,
    input  logic [5:0]         i_cell_row,
    input  logic [5:0]         i_cell_col,
    input  logic               i_layer,
    input  logic [1:0]         i_anchor_slot,
    // detection
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_confidence,
    output logic [11:0]        o_centre_x,
    output logic [11:0]        o_centre_y,
    output logic [11:0]        o_box_width,
    output logic [11:0]        o_box_height,
    output logic signed [12:0] o_left_edge,
    output logic signed [12:0] o_top_edge,
    output logic [12:0]        o_right_edge,
    output logic [12:0]        o_bottom_edge,
    output logic               o_source_layer
);
    import ybd_pkg::*;

    localparam int unsigned META_LEN = EXP_LAT + DIV_STEPS + 1;

    // config registers
    logic [15:0]        r_conf_threshold;
    logic signed [7:0]  r_zero_point_a, r_zero_point_b;
    logic [23:0]        r_scale_a, r_scale_b;
    logic [8:0]         r_cell_pixels_a, r_cell_pixels_b;

    logic en;

    // dequant stage
    logic signed [23:0] r_dy, r_dx, r_dw, r_dh, r_dc;
    t_meta              r_meta [META_LEN];
    t_meta              n_meta;
    logic signed [7:0]  zp_in;
    logic [23:0]        sc_in;

    logic [31:0] e_y, e_x, e_w, e_h, e_c;
    logic [15:0] s_y, s_x, s_c;
    t_exp_pair   r_ewh [DIV_STEPS];

    // scaling stage
    logic        r_c_valid;
    logic [15:0] r_c_conf;
    logic [11:0] r_c_cx, r_c_cy, r_c_bw, r_c_bh;
    logic        r_c_layer;

    // output stage
    logic               r_out_valid;
    logic [15:0]        r_out_conf;
    logic [11:0]        r_out_cx, r_out_cy, r_out_bw, r_out_bh;
    logic signed [12:0] r_out_left, r_out_top;
    logic [12:0]        r_out_right, r_out_bottom;
    logic               r_out_layer;

    t_meta       mt;
    logic [8:0]  cell_px;
    logic [30:0] cx_prod, cy_prod;
    logic [54:0] bw_prod, bh_prod;
    logic [11:0] n_cx, n_cy, n_bw, n_bh;

    function automatic logic signed [23:0] dequant(
        input logic signed [7:0] raw,
        input logic signed [7:0] zp,
        input logic [23:0]       sc
    );
        logic signed [8:0]  df;
        logic signed [33:0] pr;
        df = {raw[7], raw} - {zp[7], zp};
        pr = 34'(df) * $signed({10'b0, sc});
        if (pr > 34'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (pr < -34'sd8388608) begin
            return 24'sh800000;
        end else begin
            return pr[23:0];
        end
    endfunction

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_threshold <= CONF_THRESHOLD_RST;
            r_zero_point_a   <= '0;
            r_zero_point_b   <= '0;
            r_scale_a        <= SCALE_RST;
            r_scale_b        <= SCALE_RST;
            r_cell_pixels_a  <= CELL_PIXELS_A_RST;
            r_cell_pixels_b  <= CELL_PIXELS_B_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CONF_THRESHOLD: r_conf_threshold <= i_cfg_data[15:0];
                CFG_ZERO_POINT_A:   r_zero_point_a   <= i_cfg_data[7:0];
                CFG_ZERO_POINT_B:   r_zero_point_b   <= i_cfg_data[7:0];
                CFG_SCALE_A:        r_scale_a        <= i_cfg_data;
                CFG_SCALE_B:        r_scale_b        <= i_cfg_data;
                CFG_CELL_PIXELS_A:  r_cell_pixels_a  <= i_cfg_data[8:0];
                CFG_CELL_PIXELS_B:  r_cell_pixels_b  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // stage 1: dequantize; slot index past the last anchor clamps to it
    always_comb begin
        zp_in        = i_layer ? r_zero_point_b : r_zero_point_a;
        sc_in        = i_layer ? r_scale_b : r_scale_a;
        n_meta.valid = i_in_valid;
        n_meta.row   = i_cell_row;
        n_meta.col   = i_cell_col;
        n_meta.layer = i_layer;
        n_meta.slot  = (32'(i_anchor_slot) > ANCHORS_PER_LAYER - 1)
                     ? 2'(ANCHORS_PER_LAYER - 1) : i_anchor_slot;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dy <= dequant(i_raw_y, zp_in, sc_in);
            r_dx <= dequant(i_raw_x, zp_in, sc_in);
            r_dw <= dequant(i_raw_w, zp_in, sc_in);
            r_dh <= dequant(i_raw_h, zp_in, sc_in);
            r_dc <= dequant(i_raw_conf, zp_in, sc_in);
        end
    end

    // metadata and valid travel alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < META_LEN; k++) begin
                r_meta[k] <= '0;
            end
        end else if (en) begin
            r_meta[0] <= n_meta;
            for (int k = 1; k < META_LEN; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // sigmoid operands take exp(-d), box sizes exp(d)
    ybd_exp u_exp_y (.i_clk, .i_en(en), .i_d(-25'(r_dy)), .o_e(e_y));
    ybd_exp u_exp_x (.i_clk, .i_en(en), .i_d(-25'(r_dx)), .o_e(e_x));
    ybd_exp u_exp_c (.i_clk, .i_en(en), .i_d(-25'(r_dc)), .o_e(e_c));
    ybd_exp u_exp_w (.i_clk, .i_en(en), .i_d(25'(r_dw)),  .o_e(e_w));
    ybd_exp u_exp_h (.i_clk, .i_en(en), .i_d(25'(r_dh)),  .o_e(e_h));

    ybd_recip u_sig_y (.i_clk, .i_en(en), .i_e(e_y), .o_q(s_y));
    ybd_recip u_sig_x (.i_clk, .i_en(en), .i_e(e_x), .o_q(s_x));
    ybd_recip u_sig_c (.i_clk, .i_en(en), .i_e(e_c), .o_q(s_c));

    // hold box exps while the sigmoids divide
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ewh[0] <= '{ew: e_w, eh: e_h};
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_ewh[k] <= r_ewh[k-1];
            end
        end
    end

    // scaling stage: centres and box sizes, saturated
    always_comb begin
        mt      = r_meta[META_LEN-1];
        cell_px = mt.layer ? r_cell_pixels_b : r_cell_pixels_a;
        cx_prod = 31'(cell_px) * 31'({mt.col, s_x});
        cy_prod = 31'(cell_px) * 31'({mt.row, s_y});
        bw_prod = 55'(anchor_w(mt.layer, mt.slot)) * 55'(r_ewh[DIV_STEPS-1].ew);
        bh_prod = 55'(anchor_h(mt.layer, mt.slot)) * 55'(r_ewh[DIV_STEPS-1].eh);
        n_cx    = (cx_prod[30:16] > 15'(COORD_MAX)) ? COORD_MAX : cx_prod[27:16];
        n_cy    = (cy_prod[30:16] > 15'(COORD_MAX)) ? COORD_MAX : cy_prod[27:16];
        n_bw    = (bw_prod[54:32] > 23'(COORD_MAX)) ? COORD_MAX : bw_prod[43:32];
        n_bh    = (bh_prod[54:32] > 23'(COORD_MAX)) ? COORD_MAX : bh_prod[43:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= mt.valid && (s_c > r_conf_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_conf  <= s_c;
            r_c_cx    <= n_cx;
            r_c_cy    <= n_cy;
            r_c_bw    <= n_bw;
            r_c_bh    <= n_bh;
            r_c_layer <= mt.layer;
        end
    end

    // output stage: corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_conf   <= r_c_conf;
            r_out_cx     <= r_c_cx;
            r_out_cy     <= r_c_cy;
            r_out_bw     <= r_c_bw;
            r_out_bh     <= r_c_bh;
            r_out_left   <= $signed(13'(r_c_cx) - 13'(r_c_bw[11:1]));
            r_out_top    <= $signed(13'(r_c_cy) - 13'(r_c_bh[11:1]));
            r_out_right  <= 13'(r_c_cx) + 13'(r_c_bw[11:1]);
            r_out_bottom <= 13'(r_c_cy) + 13'(r_c_bh[11:1]);
            r_out_layer  <= r_c_layer;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_confidence   = r_out_conf;
    assign o_centre_x     = r_out_cx;
    assign o_centre_y     = r_out_cy;
    assign o_box_width    = r_out_bw;
    assign o_box_height   = r_out_bh;
    assign o_left_edge    = r_out_left;
    assign o_top_edge     = r_out_top;
    assign o_right_edge   = r_out_right;
    assign o_bottom_edge  = r_out_bottom;
    assign o_source_layer = r_out_layer;
endmodule

/* rtl/ybd_exp.sv */
// Pipelined fixed-point exp: Q8.16 in, saturated Q16.16 out, six stages.
module ybd_exp (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [24:0] i_d,
    output logic [31:0]        o_e
);
    import ybd_pkg::*;

    logic signed [42:0] prod;
    logic signed [26:0] r_t;
    logic signed [10:0] r_n2, r_n3, r_n4, r_n5;
    logic [15:0]        r_f2, r_f3, r_f4;
    logic [16:0]        r_p2, r_p3, r_p4, r_p5;
    logic [31:0]        r_e;
    logic [25:0]        m1;
    logic [32:0]        m2, m3, m4;
    logic signed [10:0] nn;
    logic [31:0]        n_e;

    // t = d * log2(e) in Q16 fixed point, rounded down
    assign prod = 43'(i_d) * 43'sd94548;
    assign m1   = 26'(r_t[15:0]) * 26'd630;
    assign m2   = 33'(r_p2) * 33'(r_f2);
    assign m3   = 33'(r_p3) * 33'(r_f3);
    assign m4   = 33'(r_p4) * 33'(r_f4);
    assign nn   = -r_n5;

    always_comb begin
        if (!r_n5[10] && r_n5 >= 11'sd15) begin
            n_e = 32'hFFFF_FFFF;
        end else if (!r_n5[10]) begin
            n_e = 32'(r_p5) << r_n5[3:0];
        end else if (r_n5 <= -11'sd32) begin
            n_e = 32'd0;
        end else begin
            n_e = 32'(r_p5) >> nn[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t  <= prod[42:16];
            r_n2 <= r_t[26:16];
            r_f2 <= r_t[15:0];
            r_p2 <= 17'd3638 + 17'(m1[25:16]);
            r_n3 <= r_n2;
            r_f3 <= r_f2;
            r_p3 <= 17'd15743 + m2[32:16];
            r_n4 <= r_n3;
            r_f4 <= r_f3;
            r_p4 <= 17'd45426 + m3[32:16];
            r_n5 <= r_n4;
            r_p5 <= 17'd65536 + m4[32:16];
            r_e  <= n_e;
        end
    end

    assign o_e = r_e;
endmodule

/* rtl/ybd_recip.sv */
// Pipelined restoring divider for sigmoid: 2^32 / (65536 + e), one bit a stage.
module ybd_recip (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_e,
    output logic [15:0] o_q
);
    import ybd_pkg::*;

    logic [33:0] r_rem [DIV_STEPS];
    logic [32:0] r_den [DIV_STEPS];
    logic [16:0] r_q   [DIV_STEPS];
    logic [32:0] den0;
    logic [33:0] sh0;

    assign den0 = 33'(i_e) + 33'd65536;
    assign sh0  = 34'h1_0000;   // leading numerator bits, shifted once

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= den0;
            if (sh0 >= 34'(den0)) begin
                r_rem[0] <= sh0 - 34'(den0);
                r_q[0]   <= 17'd1;
            end else begin
                r_rem[0] <= sh0;
                r_q[0]   <= 17'd0;
            end
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_den[k] <= r_den[k-1];
                if ({r_rem[k-1][32:0], 1'b0} >= 34'(r_den[k-1])) begin
                    r_rem[k] <= {r_rem[k-1][32:0], 1'b0} - 34'(r_den[k-1]);
                    r_q[k]   <= {r_q[k-1][15:0], 1'b1};
                end else begin
                    r_rem[k] <= {r_rem[k-1][32:0], 1'b0};
                    r_q[k]   <= {r_q[k-1][15:0], 1'b0};
                end
            end
        end
    end

    assign o_q = r_q[DIV_STEPS-1][16] ? 16'hFFFF : r_q[DIV_STEPS-1][15:0];
endmodule
